/* design/exl_pkg.sv */
// exl_pkg: shared types and constants for the expression lexer.
// Scan modes, token kinds, result metadata and the character codes the scanner matches.
// No dependencies.
package exl_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_WORD     = 4'd1,
      MODE_INT      = 4'd2,
      MODE_INT_DOT  = 4'd3,
      MODE_DOT      = 4'd4,
      MODE_FRAC     = 4'd5,
      MODE_SLASH    = 4'd6,
      MODE_COLON    = 4'd7,
      MODE_LESS     = 4'd8,
      MODE_COMMENT  = 4'd9
   } mode_type;

   typedef enum logic [3:0] {
      KIND_WORD       = 4'd0,
      KIND_INT        = 4'd1,
      KIND_FLOAT      = 4'd2,
      KIND_OP         = 4'd3,
      KIND_ASSIGN     = 4'd4,
      KIND_DEFINE     = 4'd5,
      KIND_OPEN       = 4'd6,
      KIND_CLOSE      = 4'd7,
      KIND_CURL_OPEN  = 4'd8,
      KIND_CURL_CLOSE = 4'd9,
      KIND_GT         = 4'd10,
      KIND_LEQ        = 4'd11,
      KIND_EOL        = 4'd12,
      KIND_END        = 4'd13,
      KIND_ERROR      = 4'd14
   } kind_type;

   // up to three tokens come out of one character
   typedef logic [1:0] count_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] op_char;
   } tok_meta_type;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LCURL   = 8'h7B;
   localparam logic [7:0] CH_RCURL   = 8'h7D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   function automatic tok_meta_type mk_meta(kind_type kind, logic [7:0] op_char);
      tok_meta_type m;
      m.kind    = kind;
      m.op_char = op_char;
      return m;
   endfunction

endpackage

/* design/exl_core.sv */
// exl_core: scanner state and one-character lexing step.
// Produces up to three tokens per character plus next scan mode and counters.
// Depends on exl_pkg.
module exl_core #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 ch,
   input  logic                       eoi,
   output exl_pkg::tok_meta_type      res_meta [3],
   output logic [COLUMN_BITS-1:0]     res_col  [3],
   output logic [COLUMN_BITS-1:0]     res_len  [3],
   output exl_pkg::count_type         res_cnt,
   output logic [LINE_BITS-1:0]       res_line
);

   localparam logic [COLUMN_BITS-1:0] LenOne = COLUMN_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] LenTwo = COLUMN_BITS'(2);

   exl_pkg::mode_type          mode_ff, mode_in;
   logic [LINE_BITS-1:0]       line_ff, line_in;
   logic [COLUMN_BITS-1:0]     colc_ff, colc_in;
   logic [COLUMN_BITS-1:0]     tstart_ff, tstart_in;
   logic [COLUMN_BITS-1:0]     tlen_ff, tlen_in;

   logic ch_alpha, ch_digit, ch_newline;

   // pending-token flush
   exl_pkg::tok_meta_type      fl_meta [2];
   logic [COLUMN_BITS-1:0]     fl_col  [2];
   logic [COLUMN_BITS-1:0]     fl_len  [2];
   exl_pkg::count_type         fl_n;
   logic [COLUMN_BITS:0]       err_sum;

   // character lexed from idle
   exl_pkg::tok_meta_type      ex_meta;
   logic [COLUMN_BITS-1:0]     ex_len;
   logic                       ex_v;
   exl_pkg::mode_type          fr_mode;

   // character continues the current mode
   logic                       cont, cont_v;
   exl_pkg::tok_meta_type      cont_meta;
   logic [COLUMN_BITS-1:0]     cont_col, cont_len;
   exl_pkg::mode_type          cont_mode;
   logic [1:0]                 len_inc;
   logic [COLUMN_BITS:0]       len_sum;
   logic [COLUMN_BITS-1:0]     len_sat;

   // token appended after the flush
   exl_pkg::tok_meta_type      tail_meta;
   logic [COLUMN_BITS-1:0]     tail_col, tail_len;
   logic                       tail_v;

   assign ch_alpha   = (ch inside {[exl_pkg::CH_UPPER_A:exl_pkg::CH_UPPER_Z],
                                   [exl_pkg::CH_LOWER_A:exl_pkg::CH_LOWER_Z]});
   assign ch_digit   = (ch inside {[exl_pkg::CH_ZERO:exl_pkg::CH_NINE]});
   assign ch_newline = (ch == exl_pkg::CH_NEWLINE);

   assign err_sum = {1'b0, tstart_ff} + {1'b0, tlen_ff};
   assign len_sum = {1'b0, tlen_ff} + {{(COLUMN_BITS-1){1'b0}}, len_inc};
   assign len_sat = len_sum[COLUMN_BITS] ? '1 : len_sum[COLUMN_BITS-1:0];

   always_comb begin : flush_logic
      fl_meta[0] = '0;
      fl_meta[1] = '0;
      fl_col[0]  = tstart_ff;
      fl_col[1]  = err_sum[COLUMN_BITS] ? '1 : err_sum[COLUMN_BITS-1:0];
      fl_len[0]  = LenOne;
      fl_len[1]  = LenOne;
      fl_n       = 2'd1;
      case (mode_ff)
         exl_pkg::MODE_WORD: begin
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_WORD, 8'h00);
            fl_len[0]  = tlen_ff;
         end
         exl_pkg::MODE_INT: begin
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_INT, 8'h00);
            fl_len[0]  = tlen_ff;
         end
         exl_pkg::MODE_INT_DOT: begin
            // integer, then the dangling dot as an error
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_INT, 8'h00);
            fl_len[0]  = tlen_ff;
            fl_meta[1] = exl_pkg::mk_meta(exl_pkg::KIND_ERROR, exl_pkg::CH_DOT);
            fl_n       = 2'd2;
         end
         exl_pkg::MODE_DOT:
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_ERROR, exl_pkg::CH_DOT);
         exl_pkg::MODE_FRAC: begin
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_FLOAT, 8'h00);
            fl_len[0]  = tlen_ff;
         end
         exl_pkg::MODE_SLASH:
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_OP, exl_pkg::CH_SLASH);
         exl_pkg::MODE_COLON:
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_ERROR, exl_pkg::CH_COLON);
         exl_pkg::MODE_LESS:
            fl_meta[0] = exl_pkg::mk_meta(exl_pkg::KIND_ERROR, exl_pkg::CH_LESS);
         default:
            fl_n = 2'd0;
      endcase
   end

   always_comb begin : fresh_logic
      ex_meta = '0;
      ex_len  = LenOne;
      ex_v    = 1'b0;
      fr_mode = exl_pkg::MODE_IDLE;
      if (ch_alpha) begin
         fr_mode = exl_pkg::MODE_WORD;
      end else if (ch_digit) begin
         fr_mode = exl_pkg::MODE_INT;
      end else begin
         case (ch)
            exl_pkg::CH_NEWLINE: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_EOL, 8'h00);
               ex_len  = '0;
            end
            exl_pkg::CH_SPACE, exl_pkg::CH_TAB, exl_pkg::CH_VTAB,
            exl_pkg::CH_FFEED, exl_pkg::CH_CR: ;
            exl_pkg::CH_SEMI:  fr_mode = exl_pkg::MODE_COMMENT;
            exl_pkg::CH_DOT:   fr_mode = exl_pkg::MODE_DOT;
            exl_pkg::CH_SLASH: fr_mode = exl_pkg::MODE_SLASH;
            exl_pkg::CH_COLON: fr_mode = exl_pkg::MODE_COLON;
            exl_pkg::CH_LESS:  fr_mode = exl_pkg::MODE_LESS;
            exl_pkg::CH_PLUS, exl_pkg::CH_MINUS, exl_pkg::CH_STAR: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_OP, ch);
            end
            exl_pkg::CH_EQUAL: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_ASSIGN, 8'h00);
            end
            exl_pkg::CH_LPAREN: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_OPEN, 8'h00);
            end
            exl_pkg::CH_RPAREN: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_CLOSE, 8'h00);
            end
            exl_pkg::CH_LCURL: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_CURL_OPEN, 8'h00);
            end
            exl_pkg::CH_RCURL: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_CURL_CLOSE, 8'h00);
            end
            exl_pkg::CH_GREATER: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_GT, 8'h00);
            end
            default: begin
               ex_v    = 1'b1;
               ex_meta = exl_pkg::mk_meta(exl_pkg::KIND_ERROR, ch);
            end
         endcase
      end
   end

   always_comb begin : cont_logic
      cont      = 1'b0;
      cont_v    = 1'b0;
      cont_meta = '0;
      cont_col  = tstart_ff;
      cont_len  = LenTwo;
      cont_mode = mode_ff;
      len_inc   = 2'd0;
      case (mode_ff)
         exl_pkg::MODE_COMMENT: begin
            cont = 1'b1;
            if (ch_newline) begin
               cont_v    = 1'b1;
               cont_meta = exl_pkg::mk_meta(exl_pkg::KIND_EOL, 8'h00);
               cont_col  = colc_ff;
               cont_len  = '0;
               cont_mode = exl_pkg::MODE_IDLE;
            end
         end
         exl_pkg::MODE_WORD: begin
            if (ch_alpha) begin
               cont    = 1'b1;
               len_inc = 2'd1;
            end
         end
         exl_pkg::MODE_INT: begin
            if (ch_digit) begin
               cont    = 1'b1;
               len_inc = 2'd1;
            end else if (ch == exl_pkg::CH_DOT) begin
               cont      = 1'b1;
               cont_mode = exl_pkg::MODE_INT_DOT;
            end
         end
         exl_pkg::MODE_INT_DOT: begin
            if (ch_digit) begin
               cont      = 1'b1;
               len_inc   = 2'd2;   // the dot and the digit
               cont_mode = exl_pkg::MODE_FRAC;
            end
         end
         exl_pkg::MODE_DOT: begin
            if (ch_digit) begin
               cont      = 1'b1;
               len_inc   = 2'd1;
               cont_mode = exl_pkg::MODE_FRAC;
            end
         end
         exl_pkg::MODE_FRAC: begin
            if (ch_digit) begin
               cont    = 1'b1;
               len_inc = 2'd1;
            end
         end
         exl_pkg::MODE_SLASH: begin
            if (ch == exl_pkg::CH_SLASH) begin
               cont      = 1'b1;
               cont_mode = exl_pkg::MODE_COMMENT;
            end
         end
         exl_pkg::MODE_COLON: begin
            if (ch == exl_pkg::CH_EQUAL) begin
               cont      = 1'b1;
               cont_v    = 1'b1;
               cont_meta = exl_pkg::mk_meta(exl_pkg::KIND_DEFINE, 8'h00);
               cont_mode = exl_pkg::MODE_IDLE;
            end
         end
         exl_pkg::MODE_LESS: begin
            if (ch == exl_pkg::CH_EQUAL) begin
               cont      = 1'b1;
               cont_v    = 1'b1;
               cont_meta = exl_pkg::mk_meta(exl_pkg::KIND_LEQ, 8'h00);
               cont_mode = exl_pkg::MODE_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_comb begin : result_logic
      if (eoi) begin
         tail_v    = 1'b1;
         tail_meta = exl_pkg::mk_meta(exl_pkg::KIND_END, 8'h00);
         tail_col  = colc_ff;
         tail_len  = '0;
      end else begin
         tail_v    = ex_v;
         tail_meta = ex_meta;
         tail_col  = colc_ff;
         tail_len  = ex_len;
      end

      res_meta[0] = fl_meta[0];
      res_meta[1] = fl_meta[1];
      res_meta[2] = '0;
      res_col[0]  = fl_col[0];
      res_col[1]  = fl_col[1];
      res_col[2]  = '0;
      res_len[0]  = fl_len[0];
      res_len[1]  = fl_len[1];
      res_len[2]  = '0;
      res_cnt     = '0;
      if (!eoi && cont) begin
         res_meta[0] = cont_meta;
         res_col[0]  = cont_col;
         res_len[0]  = cont_len;
         res_cnt     = {1'b0, cont_v};
      end else begin
         res_meta[fl_n] = tail_meta;
         res_col[fl_n]  = tail_col;
         res_len[fl_n]  = tail_len;
         res_cnt        = fl_n + {1'b0, tail_v};
      end
   end

   assign res_line = line_ff;

   always_comb begin : next_state
      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      line_in   = line_ff;
      colc_in   = colc_ff;
      if (eoi) begin
         mode_in = exl_pkg::MODE_IDLE;
      end else begin
         if (cont) begin
            mode_in = cont_mode;
            tlen_in = len_sat;
         end else begin
            mode_in   = fr_mode;
            tstart_in = colc_ff;
            tlen_in   = LenOne;
         end
         if (ch_newline) begin
            line_in = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
            colc_in = '0;
         end else begin
            colc_in = (colc_ff == '1) ? colc_ff : colc_ff + LenOne;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= exl_pkg::MODE_IDLE;
         line_ff   <= LINE_BITS'(1);
         colc_ff   <= '0;
         tstart_ff <= '0;
         tlen_ff   <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         colc_ff   <= colc_in;
         tstart_ff <= tstart_in;
         tlen_ff   <= tlen_in;
      end
   end

   // end of input always leaves the scanner idle with counters held
   a_eoi_idle: assert property (@(posedge clock) disable iff (reset)
      step && eoi |=> mode_ff == exl_pkg::MODE_IDLE)
      else $error("scanner not idle after end of input");

   a_eoi_line: assert property (@(posedge clock) disable iff (reset)
      step && eoi |=> line_ff == $past(line_ff) && colc_ff == $past(colc_ff))
      else $error("counters moved on end of input");

   a_eoi_emits: assert property (@(posedge clock) disable iff (reset)
      step && eoi |-> res_cnt != 2'd0)
      else $error("end of input gave no token");

   a_newline_emits: assert property (@(posedge clock) disable iff (reset)
      step && !eoi && ch_newline |-> res_cnt != 2'd0)
      else $error("newline gave no end of line token");

   a_intdot_flush: assert property (@(posedge clock) disable iff (reset)
      step && !eoi && mode_ff == exl_pkg::MODE_INT_DOT && !ch_digit
      |-> res_cnt == 2'd2 || res_cnt == 2'd3)
      else $error("integer and dot error not both emitted");

endmodule

/* design/exl_outbuf.sv */
// exl_outbuf: result register holding the tokens of one character.
// Drains them one word per cycle on the rsp_ channel while rsp_ready is high.
// Depends on exl_pkg.
module exl_outbuf #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  exl_pkg::tok_meta_type      in_meta [3],
   input  logic [COLUMN_BITS-1:0]     in_col  [3],
   input  logic [COLUMN_BITS-1:0]     in_len  [3],
   input  exl_pkg::count_type         in_cnt,
   input  logic [LINE_BITS-1:0]       in_line,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [3:0]                 rsp_kind,
   output logic [7:0]                 rsp_op_char,
   output logic [LINE_BITS-1:0]       rsp_line_number,
   output logic [COLUMN_BITS-1:0]     rsp_start_column,
   output logic [COLUMN_BITS-1:0]     rsp_token_length,
   output logic                       rsp_last_of_run
);

   exl_pkg::tok_meta_type      meta_ff [3];
   logic [COLUMN_BITS-1:0]     col_ff  [3];
   logic [COLUMN_BITS-1:0]     len_ff  [3];
   logic [LINE_BITS-1:0]       line_ff;
   exl_pkg::count_type         left_ff;
   logic [1:0]                 rd_ff;

   assign rsp_valid = (left_ff != 2'd0);
   // refill while the last word is being taken
   assign free      = (left_ff == 2'd0) || (left_ff == 2'd1 && rsp_ready);

   assign rsp_kind         = meta_ff[rd_ff].kind;
   assign rsp_op_char      = meta_ff[rd_ff].op_char;
   assign rsp_line_number  = line_ff;
   assign rsp_start_column = col_ff[rd_ff];
   assign rsp_token_length = len_ff[rd_ff];
   assign rsp_last_of_run  = (left_ff == 2'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         rd_ff   <= '0;
      end else if (load) begin
         left_ff <= in_cnt;
         rd_ff   <= '0;
      end else if (rsp_valid && rsp_ready) begin
         left_ff <= left_ff - 2'd1;
         rd_ff   <= rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         meta_ff <= in_meta;
         col_ff  <= in_col;
         len_ff  <= in_len;
         line_ff <= in_line;
      end
   end

endmodule

/* design/expression_lexer.sv */
// Expression lexer: one source character per word in, zero to three tokens out.
// Path: a taken req_ word passes the input register and is then lexed into the result
// register, from which its first token is valid on the rsp_ port.
// Throughput: one character per cycle while each gives at most one token and rsp_ready is high;
// a character giving several tokens holds the rsp_ port until all are taken, one token per cycle.
// Reset (synchronous, active high): scanner idle, line 1, column 0, all buffers empty.
module expression_lexer #(
   parameter int LINE_BITS   = 16,
   parameter int COLUMN_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_ch,
   input  logic                       req_end_of_input,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [3:0]                 rsp_kind,
   output logic [7:0]                 rsp_op_char,
   output logic [LINE_BITS-1:0]       rsp_line_number,
   output logic [COLUMN_BITS-1:0]     rsp_start_column,
   output logic [COLUMN_BITS-1:0]     rsp_token_length,
   output logic                       rsp_last_of_run
);

   logic                       in_valid_ff;
   logic [7:0]                 ch_ff;
   logic                       eoi_ff;
   logic                       buf_free;
   logic                       step;

   exl_pkg::tok_meta_type      res_meta [3];
   logic [COLUMN_BITS-1:0]     res_col  [3];
   logic [COLUMN_BITS-1:0]     res_len  [3];
   exl_pkg::count_type         res_cnt;
   logic [LINE_BITS-1:0]       res_line;

   assign step      = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         ch_ff  <= req_ch;
         eoi_ff <= req_end_of_input;
      end
   end

   exl_core #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .ch       (ch_ff),
      .eoi      (eoi_ff),
      .res_meta (res_meta),
      .res_col  (res_col),
      .res_len  (res_len),
      .res_cnt  (res_cnt),
      .res_line (res_line)
   );

   exl_outbuf #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_outbuf (
      .clock            (clock),
      .reset            (reset),
      .load             (step),
      .in_meta          (res_meta),
      .in_col           (res_col),
      .in_len           (res_len),
      .in_cnt           (res_cnt),
      .in_line          (res_line),
      .free             (buf_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_op_char      (rsp_op_char),
      .rsp_line_number  (rsp_line_number),
      .rsp_start_column (rsp_start_column),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

/* bench/lexer_check_pkg.sv */
// lexer_check_pkg: token predictor and scoreboard for the expression lexer bench.
// Depends on exl_pkg (scan modes, token kinds, character codes).
package lexer_check_pkg;
   import exl_pkg::*;

   localparam int LINE_W = 16;
   localparam int COL_W  = 12;
   localparam logic [LINE_W-1:0] LINE_TOP = '1;
   localparam logic [COL_W-1:0]  COL_TOP  = '1;

   typedef struct {
      kind_type          kind;
      logic [7:0]        op_char;
      logic [LINE_W-1:0] line_no;
      logic [COL_W-1:0]  column;
      logic [COL_W-1:0]  length;
      logic              last;
   } token_rec;

   class lexer_scoreboard;
      mode_type          mode;
      logic [LINE_W-1:0] line_cnt;
      logic [COL_W-1:0]  col_cnt;
      logic [COL_W-1:0]  tok_start;
      logic [COL_W-1:0]  tok_len;
      token_rec          step_toks[$];
      token_rec          awaiting[$];
      int                failures;
      int                tokens_checked;

      function new();
         mode           = MODE_IDLE;
         line_cnt       = 1;
         col_cnt        = 0;
         tok_start      = 0;
         tok_len        = 0;
         failures       = 0;
         tokens_checked = 0;
      endfunction

      function logic [COL_W-1:0] col_add(logic [COL_W-1:0] a, int unsigned b);
         logic [COL_W:0] s;
         s = {1'b0, a} + (COL_W+1)'(b);
         return (s > COL_TOP) ? COL_TOP : s[COL_W-1:0];
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function void add_tok(kind_type k, logic [7:0] op, logic [COL_W-1:0] col,
                            logic [COL_W-1:0] len);
         token_rec t;
         if (step_toks.size() >= 3) return;
         t.kind    = k;
         t.op_char = op;
         t.line_no = line_cnt;
         t.column  = col;
         t.length  = len;
         t.last    = 1'b0;
         step_toks.push_back(t);
      endfunction

      // close out whatever token the current mode was building
      function void flush_pending();
         case (mode)
            MODE_WORD:    add_tok(KIND_WORD, 8'h00, tok_start, tok_len);
            MODE_INT:     add_tok(KIND_INT, 8'h00, tok_start, tok_len);
            MODE_INT_DOT: begin
               add_tok(KIND_INT, 8'h00, tok_start, tok_len);
               add_tok(KIND_ERROR, CH_DOT, col_add(tok_start, tok_len), 1);
            end
            MODE_DOT:     add_tok(KIND_ERROR, CH_DOT, tok_start, 1);
            MODE_FRAC:    add_tok(KIND_FLOAT, 8'h00, tok_start, tok_len);
            MODE_SLASH:   add_tok(KIND_OP, CH_SLASH, tok_start, 1);
            MODE_COLON:   add_tok(KIND_ERROR, CH_COLON, tok_start, 1);
            MODE_LESS:    add_tok(KIND_ERROR, CH_LESS, tok_start, 1);
            default: ;
         endcase
         mode = MODE_IDLE;
      endfunction

      function void start_fresh(logic [7:0] c, logic [COL_W-1:0] col);
         mode      = MODE_IDLE;
         tok_start = col;
         tok_len   = 1;
         if (is_letter(c)) begin
            mode = MODE_WORD;
            return;
         end
         if (is_digit(c)) begin
            mode = MODE_INT;
            return;
         end
         case (c)
            CH_NEWLINE: add_tok(KIND_EOL, 8'h00, col, 0);
            CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR: ;
            CH_SEMI:    mode = MODE_COMMENT;
            CH_DOT:     mode = MODE_DOT;
            CH_SLASH:   mode = MODE_SLASH;
            CH_COLON:   mode = MODE_COLON;
            CH_LESS:    mode = MODE_LESS;
            CH_PLUS, CH_MINUS, CH_STAR: add_tok(KIND_OP, c, col, 1);
            CH_EQUAL:   add_tok(KIND_ASSIGN, 8'h00, col, 1);
            CH_LPAREN:  add_tok(KIND_OPEN, 8'h00, col, 1);
            CH_RPAREN:  add_tok(KIND_CLOSE, 8'h00, col, 1);
            CH_LCURL:   add_tok(KIND_CURL_OPEN, 8'h00, col, 1);
            CH_RCURL:   add_tok(KIND_CURL_CLOSE, 8'h00, col, 1);
            CH_GREATER: add_tok(KIND_GT, 8'h00, col, 1);
            default:    add_tok(KIND_ERROR, c, col, 1);
         endcase
      endfunction

      function void scan_char(logic [7:0] c, logic [COL_W-1:0] col);
         case (mode)
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  mode = MODE_IDLE;
                  add_tok(KIND_EOL, 8'h00, col, 0);
               end
               return;
            end
            MODE_WORD: begin
               if (is_letter(c)) begin
                  tok_len = col_add(tok_len, 1);
                  return;
               end
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  tok_len = col_add(tok_len, 1);
                  return;
               end
               if (c == CH_DOT) begin
                  mode = MODE_INT_DOT;
                  return;
               end
            end
            MODE_INT_DOT, MODE_DOT: begin
               // the dot joins the length only once a digit follows it
               if (is_digit(c)) begin
                  tok_len = col_add(tok_len, (mode == MODE_INT_DOT) ? 2 : 1);
                  mode    = MODE_FRAC;
                  return;
               end
            end
            MODE_FRAC: begin
               if (is_digit(c)) begin
                  tok_len = col_add(tok_len, 1);
                  return;
               end
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  mode = MODE_COMMENT;
                  return;
               end
            end
            MODE_COLON: begin
               if (c == CH_EQUAL) begin
                  add_tok(KIND_DEFINE, 8'h00, tok_start, 2);
                  mode = MODE_IDLE;
                  return;
               end
            end
            MODE_LESS: begin
               if (c == CH_EQUAL) begin
                  add_tok(KIND_LEQ, 8'h00, tok_start, 2);
                  mode = MODE_IDLE;
                  return;
               end
            end
            default: ;
         endcase
         flush_pending();
         start_fresh(c, col);
      endfunction

      // called once per accepted input word
      function void note_char(logic [7:0] c, logic eoi);
         step_toks.delete();
         if (eoi) begin
            flush_pending();
            add_tok(KIND_END, 8'h00, col_cnt, 0);
         end else begin
            scan_char(c, col_cnt);
            if (c == CH_NEWLINE) begin
               line_cnt = (line_cnt == LINE_TOP) ? LINE_TOP : line_cnt + 1'b1;
               col_cnt  = 0;
            end else begin
               col_cnt = col_add(col_cnt, 1);
            end
         end
         if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
         foreach (step_toks[i]) awaiting.push_back(step_toks[i]);
      endfunction

      function void field_check(string field, logic [31:0] want_v, logic [31:0] got_v,
                                realtime stamp);
         if (want_v !== got_v) begin
            failures++;
            $display("%0.1f ns: token %0d %s mismatch: expected %0d, actual %0d",
                     stamp, tokens_checked, field, want_v, got_v);
         end
      endfunction

      function void check_token(logic [3:0] kind, logic [7:0] op_char,
                                logic [LINE_W-1:0] line_no, logic [COL_W-1:0] column,
                                logic [COL_W-1:0] length, logic last, realtime stamp);
         token_rec want;
         if (awaiting.size() == 0) begin
            failures++;
            $display("%0.1f ns: unexpected token: expected none, %s %0d line %0d col %0d",
                     stamp, "actual kind", kind, line_no, column);
            return;
         end
         want = awaiting.pop_front();
         tokens_checked++;
         field_check("kind", 32'(want.kind), 32'(kind), stamp);
         field_check("op_char", 32'(want.op_char), 32'(op_char), stamp);
         field_check("line_number", 32'(want.line_no), 32'(line_no), stamp);
         field_check("start_column", 32'(want.column), 32'(column), stamp);
         field_check("token_length", 32'(want.length), 32'(length), stamp);
         field_check("last_of_run", 32'(want.last), 32'(last), stamp);
      endfunction
   endclass

endpackage

/* bench/tb_expression_lexer.sv */
// tb_expression_lexer: self-checking bench for the expression lexer.
// Feeds character words with random gaps and result stalls; tokens are checked by
// lexer_check_pkg. Depends on exl_pkg, lexer_check_pkg and the expression_lexer RTL.
module tb_expression_lexer;
   timeunit 1ns;
   timeprecision 1ps;

   import exl_pkg::*;
   import lexer_check_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 150_000;
   localparam int RANDOM_CHARS = 370;
   localparam int DRAIN_LIMIT  = 4000;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [7:0]        req_ch           = 8'h00;
   logic              req_end_of_input = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [3:0]        rsp_kind;
   logic [7:0]        rsp_op_char;
   logic [LINE_W-1:0] rsp_line_number;
   logic [COL_W-1:0]  rsp_start_column;
   logic [COL_W-1:0]  rsp_token_length;
   logic              rsp_last_of_run;

   lexer_scoreboard expected_tokens = new();

   int     max_gap     = 0;
   int     max_stall   = 0;
   int     chars_sent  = 0;
   longint cycle_count = 0;

   logic [7:0] single_chars [10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQUAL,
                                     CH_LPAREN, CH_RPAREN, CH_LCURL, CH_RCURL, CH_GREATER};
   logic [7:0] blank_chars [5] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR};

   expression_lexer #(
      .LINE_BITS   (LINE_W),
      .COLUMN_BITS (COL_W)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_op_char      (rsp_op_char),
      .rsp_line_number  (rsp_line_number),
      .rsp_start_column (rsp_start_column),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] rand_letter();
      return $urandom_range(0, 1) ? 8'(CH_UPPER_A + $urandom_range(0, 25))
                                  : 8'(CH_LOWER_A + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(CH_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic int pick_limit();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 16;
      endcase
   endfunction

   // valid stays up across back-to-back words; only dropped for a real gap
   task automatic send_item(input logic [7:0] c, input logic eoi);
      int gap;
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ch           <= c;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_tokens.note_char(c, eoi);
      chars_sent++;
   endtask

   task automatic put(input logic [7:0] c);
      send_item(c, 1'b0);
   endtask

   task automatic send_digits(input int n);
      repeat (n) put(rand_digit());
   endtask

   // mostly well-formed lexemes with random content, some broken ones and noise
   task automatic send_phrase();
      int pick;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         repeat ($urandom_range(1, 6)) put(rand_letter());
      end else if (pick < 26) begin
         send_digits($urandom_range(1, 5));
      end else if (pick < 36) begin
         send_digits($urandom_range(0, 3));
         put(CH_DOT);
         send_digits($urandom_range(1, 3));
      end else if (pick < 50) begin
         put(single_chars[$urandom_range(0, 9)]);
      end else if (pick < 55) begin
         put(CH_COLON);
         put(CH_EQUAL);
      end else if (pick < 60) begin
         put(CH_LESS);
         put(CH_EQUAL);
      end else if (pick < 66) begin
         put(CH_NEWLINE);
      end else if (pick < 72) begin
         if ($urandom_range(0, 1)) begin
            put(CH_SEMI);
         end else begin
            put(CH_SLASH);
            put(CH_SLASH);
         end
         repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
            put(c);
         end
         if ($urandom_range(0, 4) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
         else put(CH_NEWLINE);
      end else if (pick < 77) begin
         repeat ($urandom_range(1, 3)) put(blank_chars[$urandom_range(0, 4)]);
      end else if (pick < 80) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0: put(CH_COLON);
            1: put(CH_LESS);
            2: put(CH_DOT);
            default: begin
               send_digits($urandom_range(1, 3));
               put(CH_DOT);
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1)) put(blank_chars[$urandom_range(0, 4)]);
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = (max_stall > 0) ? $urandom_range(0, max_stall) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         expected_tokens.check_token(rsp_kind, rsp_op_char, rsp_line_number,
                                     rsp_start_column, rsp_token_length,
                                     rsp_last_of_run, $realtime);
      end
   end

   initial begin
      string opening;
      int    base;
      int    drain;
      opening = "Zz9.5.7\t3.:=:(<=<)+-*{/}=>";
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: every token kind, broken lexemes, byte extremes, end inside a comment
      max_gap   = 2;
      max_stall = 2;
      for (int i = 0; i < opening.len(); i++) put(opening[i]);
      put(8'h00);
      put(8'hFF);
      put(CH_SEMI);
      put(CH_NEWLINE);
      put(rand_digit());
      send_item(8'hFF, 1'b1);
      put(CH_SLASH);
      put(CH_SLASH);
      send_item(8'h00, 1'b1);

      // random phase, idling profile changes now and then
      base = chars_sent;
      while (chars_sent - base < RANDOM_CHARS) begin
         if ($urandom_range(0, 11) == 0) begin
            max_gap   = pick_limit();
            max_stall = pick_limit();
         end
         send_phrase();
      end

      send_item(8'h00, 1'b1);
      req_valid <= 1'b0;

      drain = 0;
      while (expected_tokens.awaiting.size() > 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (expected_tokens.awaiting.size() > 0) begin
         $display("%0.1f ns: %0d tokens never arrived, expected kind %0d first, actual none",
                  $realtime, expected_tokens.awaiting.size(),
                  expected_tokens.awaiting[0].kind);
         expected_tokens.failures += expected_tokens.awaiting.size();
      end
      if (expected_tokens.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
design/exl_pkg.sv
design/exl_core.sv
design/exl_outbuf.sv
design/expression_lexer.sv
bench/lexer_check_pkg.sv
bench/tb_expression_lexer.sv
